@@ design/parf_pkg.sv @@
// Package with the codes, constants, types and helper functions of the request framer.
`default_nettype none
package parf_pkg;

    localparam int FRAME_LEN = 12;
    localparam int LEN_W     = 4;

    typedef enum logic [2:0] {
        CMD_READ_BITS  = 3'd0,
        CMD_SET_BIT    = 3'd1,
        CMD_RESET_BIT  = 3'd2,
        CMD_READ_WORDS = 3'd3,
        CMD_WRITE      = 3'd4,
        CMD_DATA       = 3'd5
    } cmd_t;

    localparam logic [3:0] AREA_Y         = 4'd0;
    localparam logic [3:0] AREA_M         = 4'd1;
    localparam logic [3:0] AREA_L         = 4'd2;
    localparam logic [3:0] AREA_K         = 4'd3;
    localparam logic [3:0] AREA_T         = 4'd4;
    localparam logic [3:0] AREA_C         = 4'd5;
    localparam logic [3:0] AREA_LAST_BIT  = 4'd5;
    localparam logic [3:0] AREA_D         = 4'd6;
    localparam logic [3:0] AREA_TIMER     = 4'd7;
    localparam logic [3:0] AREA_COUNTER   = 4'd8;

    localparam logic [7:0] CH_ENQ        = 8'h05;
    localparam logic [7:0] CH_STX        = 8'h02;
    localparam logic [7:0] CH_EOT        = 8'h04;
    localparam logic [7:0] CH_F          = 8'h46;
    localparam logic [7:0] CH_KIND_BIT   = 8'h42;
    localparam logic [7:0] CH_KIND_WORD  = 8'h43;
    localparam logic [7:0] LETTER_READ   = 8'h67;
    localparam logic [7:0] LETTER_SET    = 8'h6f;
    localparam logic [7:0] LETTER_RESET  = 8'h70;
    localparam logic [7:0] LETTER_WRITE  = 8'h77;

    typedef struct packed {
        logic [7:0] data;
        logic       await_reply;
        logic       last;
    } frame_byte_t;

    typedef struct packed {
        frame_byte_t [FRAME_LEN-1:0] bytes;
        logic [LEN_W-1:0]            len;
    } frame_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] v;
        v = {4'h0, n};
        if (n < 4'd10)
        begin
            return 8'h30 + v;
        end
        return 8'h37 + v;
    endfunction

    function automatic logic [7:0] bit_offset(input logic [3:0] area);
        logic [7:0] off;
        case (area)
            AREA_Y:  off = 8'ha0;
            AREA_M:  off = 8'h80;
            AREA_L:  off = 8'hb4;
            AREA_K:  off = 8'ha4;
            AREA_T:  off = 8'he4;
            AREA_C:  off = 8'hea;
            default: off = 8'h00;
        endcase
        return off;
    endfunction

    function automatic logic [7:0] word_offset(input logic [3:0] area);
        logic [7:0] off;
        case (area)
            AREA_D:     off = 8'h80;
            AREA_TIMER: off = 8'h00;
            default:    off = 8'h60;
        endcase
        return off;
    endfunction

    function automatic frame_byte_t plain(input logic [7:0] b);
        frame_byte_t e;
        e.data        = b;
        e.await_reply = 1'b0;
        e.last        = 1'b0;
        return e;
    endfunction

endpackage
`default_nettype wire

@@ design/parf_ifs.sv @@
// Handshake interfaces for request items and frame bytes.
`default_nettype none
interface parf_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [3:0]  area;
    logic [15:0] address;
    logic [7:0]  count;
    logic [15:0] data_word;

    modport source (output valid, output cmd, output area, output address, output count,
                    output data_word, input ready);
    modport sink (input valid, input cmd, input area, input address, input count,
                  input data_word, output ready);
endinterface

interface parf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       await_reply;
    logic       last;

    modport source (output valid, output out_byte, output await_reply, output last,
                    input ready);
    modport sink (input valid, input out_byte, input await_reply, input last,
                  output ready);
endinterface
`default_nettype wire

@@ design/parf_builder.sv @@
// Frame builder: holds the write state and turns one request item into its frame bytes.
`default_nettype none
module parf_builder
    import parf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [2:0]  cmd,
    input  wire logic [3:0]  area,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  count,
    input  wire logic [15:0] data_word,
    output frame_t           frame
);

    logic       write_open_reg;
    logic       write_open_next;
    logic [7:0] words_left_reg;
    logic [7:0] words_left_next;
    logic [7:0] running_sum_reg;
    logic [7:0] running_sum_next;

    logic       bit_area;
    logic       word_area;
    logic       is_request;
    logic       req_ok;
    logic [7:0] letter;
    logic [7:0] kind;
    logic [7:0] addr_byte;
    logic [7:0] len_byte;
    logic [7:0] mask;
    logic [7:0] hdr_sum;
    logic [7:0] data_sum;
    logic [7:0] words_dec;
    logic [7:0] trail_sum;
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [7:0] d3;
    logic [7:0] a0;
    logic [7:0] a1;
    logic [7:0] l0;
    logic [7:0] l1;

    always_comb
    begin
        bit_area   = (area <= AREA_LAST_BIT);
        word_area  = (area >= AREA_D) && (area <= AREA_COUNTER);
        is_request = (cmd == CMD_READ_BITS) || (cmd == CMD_SET_BIT) ||
                     (cmd == CMD_RESET_BIT) || (cmd == CMD_READ_WORDS) ||
                     (cmd == CMD_WRITE);
        mask       = 8'h01 << address[2:0];
        kind       = CH_KIND_BIT;
        letter     = LETTER_READ;
        addr_byte  = address[10:3] + bit_offset(area);
        len_byte   = count;
        req_ok     = 1'b0;
        case (cmd)
            CMD_READ_BITS:
            begin
                req_ok = bit_area;
            end
            CMD_SET_BIT:
            begin
                req_ok   = bit_area;
                letter   = LETTER_SET;
                len_byte = mask;
            end
            CMD_RESET_BIT:
            begin
                req_ok   = bit_area;
                letter   = LETTER_RESET;
                len_byte = ~mask;
            end
            CMD_READ_WORDS, CMD_WRITE:
            begin
                req_ok    = word_area;
                kind      = CH_KIND_WORD;
                letter    = (cmd == CMD_WRITE) ? LETTER_WRITE : LETTER_READ;
                addr_byte = {address[6:0], 1'b0} + word_offset(area);
                len_byte  = {count[6:0], 1'b0};
            end
            default:
            begin
                req_ok = 1'b0;
            end
        endcase
        req_ok = req_ok && is_request && !write_open_reg;
    end

    always_comb
    begin
        a0 = hex_digit(addr_byte[7:4]);
        a1 = hex_digit(addr_byte[3:0]);
        l0 = hex_digit(len_byte[7:4]);
        l1 = hex_digit(len_byte[3:0]);
        d0 = hex_digit(data_word[7:4]);
        d1 = hex_digit(data_word[3:0]);
        d2 = hex_digit(data_word[15:12]);
        d3 = hex_digit(data_word[11:8]);
        hdr_sum   = letter + CH_F + kind + a0 + a1 + l0 + l1;
        data_sum  = running_sum_reg + d0 + d1 + d2 + d3;
        words_dec = words_left_reg - 8'd1;
    end

    always_comb
    begin
        frame            = '0;
        write_open_next  = write_open_reg;
        words_left_next  = words_left_reg;
        running_sum_next = running_sum_reg;
        trail_sum        = 8'h00;
        if ((cmd == CMD_DATA) && write_open_reg)
        begin
            frame.bytes[0]  = plain(d0);
            frame.bytes[1]  = plain(d1);
            frame.bytes[2]  = plain(d2);
            frame.bytes[3]  = plain(d3);
            frame.len       = LEN_W'(4);
            words_left_next = words_dec;
            trail_sum       = data_sum + CH_EOT;
            running_sum_next = data_sum;
            if (words_dec == 8'd0)
            begin
                write_open_next  = 1'b0;
                running_sum_next = trail_sum;
                frame.bytes[4]   = plain(CH_EOT);
                frame.bytes[5]   = plain(hex_digit(trail_sum[7:4]));
                frame.bytes[6]   = plain(hex_digit(trail_sum[3:0]));
                frame.bytes[6].await_reply = 1'b1;
                frame.bytes[6].last        = 1'b1;
                frame.len        = LEN_W'(7);
            end
        end
        else if (req_ok)
        begin
            frame.bytes[0] = plain(CH_ENQ);
            frame.bytes[0].await_reply = 1'b1;
            frame.bytes[1] = plain(CH_STX);
            frame.bytes[2] = plain(letter);
            frame.bytes[3] = plain(CH_F);
            frame.bytes[4] = plain(kind);
            frame.bytes[5] = plain(a0);
            frame.bytes[6] = plain(a1);
            frame.bytes[7] = plain(l0);
            frame.bytes[8] = plain(l1);
            trail_sum      = hdr_sum + CH_EOT;
            if ((cmd == CMD_WRITE) && (count != 8'd0))
            begin
                frame.len        = LEN_W'(9);
                write_open_next  = 1'b1;
                words_left_next  = count;
                running_sum_next = hdr_sum;
            end
            else
            begin
                frame.bytes[9]   = plain(CH_EOT);
                frame.bytes[10]  = plain(hex_digit(trail_sum[7:4]));
                frame.bytes[11]  = plain(hex_digit(trail_sum[3:0]));
                frame.bytes[11].await_reply = 1'b1;
                frame.bytes[11].last        = 1'b1;
                frame.len        = LEN_W'(12);
                running_sum_next = trail_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_open_reg  <= 1'b0;
            words_left_reg  <= 8'd0;
            running_sum_reg <= 8'd0;
        end
        else if (accept)
        begin
            write_open_reg  <= write_open_next;
            words_left_reg  <= words_left_next;
            running_sum_reg <= running_sum_next;
        end
    end

endmodule
`default_nettype wire

@@ design/parf_serializer.sv @@
// Frame serializer: a byte shift line feeding a registered output stage.
`default_nettype none
module parf_serializer
    import parf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire frame_t     frame,
    output logic            can_take,
    parf_byte_if.source     out
);

    frame_byte_t [FRAME_LEN-1:0] bytes_reg;
    frame_byte_t [FRAME_LEN-1:0] bytes_next;
    logic [LEN_W-1:0]            cnt_reg;
    logic [LEN_W-1:0]            cnt_next;
    logic                        ov_reg;
    logic                        ov_next;
    frame_byte_t                 ob_reg;
    frame_byte_t                 ob_next;
    logic                        move;

    always_comb
    begin
        move     = (cnt_reg != '0) && (!ov_reg || out.ready);
        can_take = (cnt_reg == '0) || (move && (cnt_reg == LEN_W'(1)));
    end

    always_comb
    begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg;
        ob_next    = ob_reg;
        if (move)
        begin
            ob_next  = bytes_reg[0];
            ov_next  = 1'b1;
            cnt_next = cnt_reg - LEN_W'(1);
            for (int i = 0; i < FRAME_LEN - 1; i++)
            begin
                bytes_next[i] = bytes_reg[i+1];
            end
        end
        else if (out.ready)
        begin
            ov_next = 1'b0;
        end
        if (load)
        begin
            bytes_next = frame.bytes;
            cnt_next   = frame.len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        ob_reg    <= ob_next;
    end

    assign out.valid       = ov_reg;
    assign out.out_byte    = ob_reg.data;
    assign out.await_reply = ob_reg.await_reply;
    assign out.last        = ob_reg.last;

endmodule
`default_nettype wire

@@ design/plc_ascii_request_framer_top.sv @@
// Top level of the ASCII request framer for the serial PLC link.
// The bytes of an accepted item are loaded into the shift line and leave it through a registered
// output stage, one byte per cycle while the receiver is ready; a request frame holds up to 12.
// The shift line lets the next item in while the final byte of a frame leaves,
// so frames follow one another without a gap. Items that give no bytes load nothing.
// Reset clears the write state, the shift line count and the output valid flag.
`default_nettype none
module plc_ascii_request_framer_top
    import parf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    parf_req_if.sink    req,
    parf_byte_if.source frame_out
);

    frame_t frame;
    logic   can_take;
    logic   accept;

    assign req.ready = can_take;
    assign accept    = req.valid && can_take;

    parf_builder u_builder (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (req.cmd),
        .area      (req.area),
        .address   (req.address),
        .count     (req.count),
        .data_word (req.data_word),
        .frame     (frame)
    );

    parf_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept && (frame.len != '0)),
        .frame    (frame),
        .can_take (can_take),
        .out      (frame_out)
    );

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the ASCII request framer: predicts every frame byte and compares.
`timescale 1ns / 1ps
module tb_top;
    import parf_pkg::*;

    localparam logic [3:0] AREA_UNUSED   = 4'd9;
    localparam logic [3:0] AREA_TOP      = 4'd15;
    localparam logic [2:0] CMD_SPARE_LO  = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
    localparam int         PHASE_TARGET  = 45;
    localparam int         LONG_HOLD     = 150;
    localparam int         DRAIN_CYCLES  = 40;
    localparam int         CYCLE_LIMIT   = 300000;

    class frame_byte_checker;
        frame_byte_t due_bytes[$];
        bit          write_pending;
        logic [7:0]  words_due;
        logic [7:0]  frame_sum;
        int          errors;

        function new();
            write_pending = 1'b0;
            words_due     = 8'd0;
            frame_sum     = 8'd0;
            errors        = 0;
        endfunction

        function logic [7:0] ascii_hex(logic [3:0] n);
            if (n < 4'd10)
            begin
                return 8'h30 + {4'h0, n};
            end
            return 8'h41 + {4'h0, n} - 8'd10;
        endfunction

        function void push_byte(logic [7:0] b, logic aw, logic l);
            frame_byte_t e;
            e.data        = b;
            e.await_reply = aw;
            e.last        = l;
            due_bytes.push_back(e);
        endfunction

        function void push_summed(logic [7:0] b);
            frame_sum = frame_sum + b;
            push_byte(b, 1'b0, 1'b0);
        endfunction

        function void push_hex_pair(logic [7:0] v);
            push_summed(ascii_hex(v[7:4]));
            push_summed(ascii_hex(v[3:0]));
        endfunction

        function void push_trailer();
            logic [7:0] s;
            push_summed(CH_EOT);
            s = frame_sum;
            push_byte(ascii_hex(s[7:4]), 1'b0, 1'b0);
            push_byte(ascii_hex(s[3:0]), 1'b1, 1'b1);
        endfunction

        function int accept_item(logic [2:0] c, logic [3:0] a, logic [15:0] addr,
                                 logic [7:0] cnt, logic [15:0] d);
            int         start_len;
            logic [7:0] letter;
            logic [7:0] kind;
            logic [7:0] base;
            logic [7:0] addr_byte;
            logic [7:0] len_byte;
            start_len = due_bytes.size();
            if (c == CMD_DATA)
            begin
                if (!write_pending)
                begin
                    return 0;
                end
                push_hex_pair(d[7:0]);
                push_hex_pair(d[15:8]);
                words_due = words_due - 8'd1;
                if (words_due == 8'd0)
                begin
                    write_pending = 1'b0;
                    push_trailer();
                end
                return due_bytes.size() - start_len;
            end
            if (c > CMD_DATA || write_pending)
            begin
                return 0;
            end
            if (c <= CMD_RESET_BIT)
            begin
                if (a > AREA_LAST_BIT)
                begin
                    return 0;
                end
                case (a)
                    AREA_Y:  base = 8'ha0;
                    AREA_M:  base = 8'h80;
                    AREA_L:  base = 8'hb4;
                    AREA_K:  base = 8'ha4;
                    AREA_T:  base = 8'he4;
                    default: base = 8'hea;
                endcase
                addr_byte = addr[10:3] + base;
                kind      = CH_KIND_BIT;
                if (c == CMD_READ_BITS)
                begin
                    letter   = LETTER_READ;
                    len_byte = cnt;
                end
                else if (c == CMD_SET_BIT)
                begin
                    letter   = LETTER_SET;
                    len_byte = 8'h01 << addr[2:0];
                end
                else
                begin
                    letter   = LETTER_RESET;
                    len_byte = ~(8'h01 << addr[2:0]);
                end
            end
            else
            begin
                if (a < AREA_D || a > AREA_COUNTER)
                begin
                    return 0;
                end
                case (a)
                    AREA_D:     base = 8'h80;
                    AREA_TIMER: base = 8'h00;
                    default:    base = 8'h60;
                endcase
                addr_byte = {addr[6:0], 1'b0} + base;
                kind      = CH_KIND_WORD;
                letter    = (c == CMD_READ_WORDS) ? LETTER_READ : LETTER_WRITE;
                len_byte  = {cnt[6:0], 1'b0};
            end
            frame_sum = 8'd0;
            push_byte(CH_ENQ, 1'b1, 1'b0);
            push_byte(CH_STX, 1'b0, 1'b0);
            push_summed(letter);
            push_summed(CH_F);
            push_summed(kind);
            push_hex_pair(addr_byte);
            push_hex_pair(len_byte);
            if (c == CMD_WRITE && cnt != 8'd0)
            begin
                write_pending = 1'b1;
                words_due     = cnt;
            end
            else
            begin
                push_trailer();
            end
            return due_bytes.size() - start_len;
        endfunction

        function void check_byte(logic [7:0] b, logic aw, logic l);
            frame_byte_t e;
            if (due_bytes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected frame byte %h await %b last %b", $time, b, aw, l);
                return;
            end
            e = due_bytes.pop_front();
            if (e.data !== b || e.await_reply !== aw || e.last !== l)
            begin
                errors++;
                $display("%0t: frame byte mismatch: expected %h await %b last %b,",
                         $time, e.data, e.await_reply, e.last,
                         " got %h await %b last %b", b, aw, l);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    parf_req_if  req_if ();
    parf_byte_if byte_if ();

    frame_byte_checker sb = new();
    int framed_items  = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    bit hold_off_due  = 1'b0;
    int cycle_count   = 0;

    plc_ascii_request_framer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .frame_out (byte_if)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic offer_item(input logic [2:0] c, input logic [3:0] a, input logic [15:0] addr,
                              input logic [7:0] cnt, input logic [15:0] d);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.cmd       <= c;
        req_if.area      <= a;
        req_if.address   <= addr;
        req_if.count     <= cnt;
        req_if.data_word <= d;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
        if (sb.accept_item(c, a, addr, cnt, d) > 0)
        begin
            framed_items++;
        end
    endtask

    task automatic offer_noise();
        offer_item(3'($urandom_range(7)), 4'($urandom_range(15)), 16'($urandom),
                   8'($urandom), 16'($urandom));
    endtask

    task automatic offer_write(input logic [3:0] a, input logic [7:0] cnt);
        offer_item(CMD_WRITE, a, 16'($urandom), cnt, 16'($urandom));
        for (int i = 0; i < cnt; i++)
        begin
            if ($urandom_range(19) == 0)
            begin
                offer_noise();
            end
            offer_item(CMD_DATA, 4'($urandom_range(15)), 16'($urandom), 8'($urandom),
                       16'($urandom));
        end
    endtask

    task automatic offer_request();
        logic [2:0] c;
        logic [3:0] a;
        c = 3'($urandom_range(int'(CMD_WRITE)));
        if (c <= CMD_RESET_BIT)
        begin
            a = 4'($urandom_range(int'(AREA_LAST_BIT)));
        end
        else
        begin
            a = 4'($urandom_range(int'(AREA_COUNTER), int'(AREA_D)));
        end
        if (c == CMD_WRITE)
        begin
            offer_write(a, ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(6, 1)));
        end
        else
        begin
            offer_item(c, a, 16'($urandom), 8'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        byte_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (byte_if.valid === 1'b1 && byte_if.ready === 1'b1)
            begin
                sb.check_byte(byte_if.out_byte, byte_if.await_reply, byte_if.last);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                byte_if.ready <= 1'b0;
            end
            else if (hold_off_due)
            begin
                hold_off_due = 1'b0;
                hold_left = LONG_HOLD;
                byte_if.ready <= 1'b0;
            end
            else
            begin
                byte_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        int target;
        rst_n            <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.cmd       <= CMD_READ_BITS;
        req_if.area      <= AREA_Y;
        req_if.address   <= 16'h0000;
        req_if.count     <= 8'h00;
        req_if.data_word <= 16'h0000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_item(CMD_READ_BITS,  AREA_Y,       16'h0000, 8'h00, 16'h0000);
        offer_item(CMD_READ_BITS,  AREA_C,       16'hffff, 8'hff, 16'hffff);
        offer_item(CMD_SET_BIT,    AREA_M,       16'h0000, 8'h00, 16'h0000);
        offer_item(CMD_SET_BIT,    AREA_K,       16'h0007, 8'h55, 16'h0000);
        offer_item(CMD_RESET_BIT,  AREA_L,       16'hfff8, 8'haa, 16'h0000);
        offer_item(CMD_RESET_BIT,  AREA_T,       16'hffff, 8'h00, 16'h0000);
        offer_item(CMD_READ_WORDS, AREA_D,       16'h0000, 8'h00, 16'h0000);
        offer_item(CMD_READ_WORDS, AREA_TIMER,   16'hffff, 8'hff, 16'h0000);
        offer_item(CMD_WRITE,      AREA_COUNTER, 16'h1234, 8'h00, 16'h0000);
        offer_item(CMD_DATA,       AREA_D,       16'h0000, 8'h00, 16'hffff);
        offer_item(CMD_WRITE,      AREA_D,       16'h007f, 8'h02, 16'h0000);
        offer_item(CMD_READ_BITS,  AREA_Y,       16'h0010, 8'h04, 16'h0000);
        offer_item(CMD_DATA,       AREA_D,       16'h0000, 8'h00, 16'h0000);
        offer_item(CMD_DATA,       AREA_D,       16'h0000, 8'h00, 16'hffff);
        offer_item(CMD_READ_BITS,  AREA_D,       16'h0100, 8'h01, 16'h0000);
        offer_item(CMD_READ_WORDS, AREA_Y,       16'h0100, 8'h01, 16'h0000);
        offer_item(CMD_READ_BITS,  AREA_UNUSED,  16'h0100, 8'h01, 16'h0000);
        offer_item(CMD_WRITE,      AREA_TOP,     16'h0100, 8'h01, 16'h0000);
        offer_item(CMD_SPARE_LO,   AREA_Y,       16'h0100, 8'h01, 16'h0000);
        offer_item(CMD_SPARE_HI,   AREA_D,       16'h0100, 8'h01, 16'h0000);
        offer_item(CMD_WRITE,      AREA_TIMER,   16'h8001, 8'h01, 16'h0000);
        offer_item(CMD_DATA,       AREA_TIMER,   16'h0000, 8'h00, 16'ha5c3);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 45;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 45;
                end
                default:
                begin
                    send_idle_pct = 38;
                    stall_pct     = 38;
                end
            endcase
            if (phase == 0)
            begin
                hold_off_due = 1'b1;
                offer_write(AREA_D, 8'($urandom_range(136, 128)));
            end
            target = framed_items + PHASE_TARGET;
            while (framed_items < target)
            begin
                if ($urandom_range(99) < 12)
                begin
                    offer_noise();
                end
                else
                begin
                    offer_request();
                end
            end
        end

        req_if.valid <= 1'b0;
        stall_pct = 0;
        while (sb.due_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.due_bytes.size() == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

@@ files.f @@
design/parf_pkg.sv
design/parf_ifs.sv
design/parf_builder.sv
design/parf_serializer.sv
design/plc_ascii_request_framer_top.sv
tb/tb_top.sv
